@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file of the sparse array store.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define SAS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold at every rising edge outside reset.
`define SAS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

@@ rtl/core/sas_pkg.sv @@
// Package for the sparse array store: command codes, sequencer states, field widths.
// Depends on nothing.
`default_nettype none

package sas_pkg;

    localparam int unsigned CMD_WIDTH   = 3;
    localparam int unsigned POS_WIDTH   = 32;
    localparam int unsigned FIELD_WIDTH = 32;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_READ     = 3'd0,
        CMD_ASSIGN   = 3'd1,
        CMD_ADD      = 3'd2,
        CMD_PRE_INC  = 3'd3,
        CMD_POST_INC = 3'd4
    } sas_cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_UPDATE = 4'b1000
    } sas_state_t;

endpackage

`default_nettype wire

@@ rtl/core/sparse_array_store_top.sv @@
// Each accepted word is checked against every slot in a scan, then the update step writes the
// result register. A new word is taken only in the idle state, after that result is written;
// the slot scan reads one slot a cycle from the single read port of the slot memory and one
// comparator checks it. Reset: rst_n clears control state at once, then a clearing pass marks
// every slot free; s_tready stays low during that pass.
// Depends on sas_pkg.
`default_nettype none

module sparse_array_store_top #(
    parameter int unsigned ENTRIES     = 16,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] element_index, [63:32] operand_value
    input  wire logic [2:0]  s_tuser,   // [2:0] command
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] result_value
    output logic [0:0]       m_tuser    // [0] table_full
);

    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);
    localparam int unsigned PW = sas_pkg::POS_WIDTH;
    localparam int unsigned FW = sas_pkg::FIELD_WIDTH;

    // One slot of the table: occupancy, array position and stored value.
    typedef struct packed {
        logic                   valid;
        logic [PW-1:0]          position;
        logic [VALUE_WIDTH-1:0] content;
    } slot_t;

    // Slot memory: one write port, one registered read port.
    slot_t mem [ENTRIES];
    slot_t rd_data_reg;

    sas_pkg::sas_state_t state_reg, state_next;

    logic [AW-1:0]          clr_reg, clr_next;
    logic [AW-1:0]          rd_addr_reg, rd_addr_next;
    logic [AW-1:0]          chk_reg, chk_next;
    logic                   rd_live_reg, rd_live_next;
    logic                   hit_reg, hit_next;
    logic [AW-1:0]          hit_idx_reg, hit_idx_next;
    logic [VALUE_WIDTH-1:0] old_reg, old_next;
    logic                   free_reg, free_next;
    logic [AW-1:0]          free_idx_reg, free_idx_next;
    logic [2:0]             cmd_reg, cmd_next;
    logic [PW-1:0]          pos_reg, pos_next;
    logic [VALUE_WIDTH-1:0] opv_reg, opv_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [FW-1:0]          m_tdata_reg, m_tdata_next;
    logic                   m_tuser_reg, m_tuser_next;

    logic                   mem_we;
    logic [AW-1:0]          mem_wa;
    slot_t                  mem_wd;

    logic                   s_fire;
    logic                   out_free;
    logic                   upd_fire;
    logic                   is_mod;
    logic [VALUE_WIDTH-1:0] opv_in;
    logic [VALUE_WIDTH-1:0] old_val;
    logic [VALUE_WIDTH-1:0] addend;
    logic [VALUE_WIDTH-1:0] sum;
    logic [VALUE_WIDTH-1:0] nv;
    logic [VALUE_WIDTH-1:0] res;
    logic                   nv_zero;
    logic                   full;
    logic [FW-1:0]          res_field;

    // Bring the 32-bit operand to the value width, and the result back to 32 bits.
    generate
        if (VALUE_WIDTH >= FW) begin : g_wide
            assign opv_in    = {{(VALUE_WIDTH - FW){s_tdata[63]}}, s_tdata[63:32]};
            assign res_field = res[FW-1:0];
        end else begin : g_narrow
            assign opv_in    = s_tdata[32 +: VALUE_WIDTH];
            assign res_field = {{(FW - VALUE_WIDTH){res[VALUE_WIDTH-1]}}, res};
        end
    endgenerate

    assign s_tready = (state_reg == sas_pkg::ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign upd_fire = (state_reg == sas_pkg::ST_UPDATE) && out_free;

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // Shared adder and zero test of the update step.
    always_comb
    begin
        is_mod  = (cmd_reg == sas_pkg::CMD_ASSIGN) || (cmd_reg == sas_pkg::CMD_ADD)
               || (cmd_reg == sas_pkg::CMD_PRE_INC) || (cmd_reg == sas_pkg::CMD_POST_INC);
        old_val = hit_reg ? old_reg : '0;
        addend  = (cmd_reg == sas_pkg::CMD_ADD) ? opv_reg : VALUE_WIDTH'(1);
        sum     = old_val + addend;
        if (cmd_reg == sas_pkg::CMD_ASSIGN)
            nv = opv_reg;
        else if (is_mod)
            nv = sum;
        else
            nv = old_val;
        if (is_mod && (cmd_reg != sas_pkg::CMD_POST_INC))
            res = nv;
        else
            res = old_val;
        nv_zero = (nv == '0);
        full    = is_mod && !nv_zero && !hit_reg && !free_reg;
    end

    // Sequencer: clearing pass, request capture, slot scan, update and result.
    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        rd_addr_next  = rd_addr_reg;
        chk_next      = chk_reg;
        rd_live_next  = 1'b0;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        old_next      = old_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        cmd_next      = cmd_reg;
        pos_next      = pos_reg;
        opv_next      = opv_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        mem_we        = 1'b0;
        mem_wa        = clr_reg;
        mem_wd        = '0;

        unique case (state_reg)
            sas_pkg::ST_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST)
                    state_next = sas_pkg::ST_IDLE;
            end
            sas_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    cmd_next     = s_tuser;
                    pos_next     = s_tdata[31:0];
                    opv_next     = opv_in;
                    rd_addr_next = '0;
                    hit_next     = 1'b0;
                    free_next    = 1'b0;
                    state_next   = sas_pkg::ST_SCAN;
                end
            end
            sas_pkg::ST_SCAN:
            begin
                // Issue the next read, check the slot whose read was issued in the previous cycle.
                chk_next     = rd_addr_reg;
                rd_live_next = 1'b1;
                if (rd_addr_reg != LAST)
                    rd_addr_next = rd_addr_reg + AW'(1);
                if (rd_live_reg)
                begin
                    if (rd_data_reg.valid && (rd_data_reg.position == pos_reg) && !hit_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = chk_reg;
                        old_next     = rd_data_reg.content;
                    end
                    if (!rd_data_reg.valid && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = chk_reg;
                    end
                    if (chk_reg == LAST)
                    begin
                        rd_live_next = 1'b0;
                        state_next   = sas_pkg::ST_UPDATE;
                    end
                end
            end
            sas_pkg::ST_UPDATE:
            begin
                // Hold here until the result register can take the word.
                if (upd_fire)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_field;
                    m_tuser_next  = full;
                    state_next    = sas_pkg::ST_IDLE;
                    if (is_mod && hit_reg)
                    begin
                        // Overwrite the slot, or drop it when the value became zero.
                        mem_we = 1'b1;
                        mem_wa = hit_idx_reg;
                        mem_wd = nv_zero ? slot_t'('0) : slot_t'{1'b1, pos_reg, nv};
                    end
                    else if (is_mod && !nv_zero && free_reg)
                    begin
                        mem_we = 1'b1;
                        mem_wa = free_idx_reg;
                        mem_wd = slot_t'{1'b1, pos_reg, nv};
                    end
                end
            end
            default:
            begin
                state_next = sas_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sas_pkg::ST_CLEAR;
            clr_reg      <= '0;
            rd_live_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            rd_live_reg  <= rd_live_next;
            hit_reg      <= hit_next;
            free_reg     <= free_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg  <= rd_addr_next;
        chk_reg      <= chk_next;
        hit_idx_reg  <= hit_idx_next;
        old_reg      <= old_next;
        free_idx_reg <= free_idx_next;
        cmd_reg      <= cmd_next;
        pos_reg      <= pos_next;
        opv_reg      <= opv_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    // Slot memory write port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
    end

    // Slot memory read port, registered.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr_reg];
    end

endmodule

`default_nettype wire

@@ rtl/core/sas_checker.sv @@
// Port-level checker for the sparse array store, bound to the top level.
// Depends on assert_macros.svh and sparse_array_store_top.
`default_nettype none
`include "assert_macros.svh"

module sas_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [63:0] s_tdata,
    input wire logic [2:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // A stalled result word holds.
    `SAS_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "result word changed while stalled")

    // The scan keeps the request side closed after an accept.
    `SAS_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> (!s_tready ##1 !s_tready), "request accepted during scan")

    // A new result never appears in the cycle right after an accept.
    `SAS_ASSERT(a_no_early_result, (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid, "result word before the scan finished")

endmodule

bind sparse_array_store_top sas_checker u_sas_checker (.*);

`default_nettype wire
